/* sv/lzs_pkg.sv */
// Shared types and constants for the LZS stream decompressor.
// Used by every module of the block; depends on nothing.
package lzs_pkg;

    localparam int HISTORY_DEPTH_DEF = 2048;
    localparam int STEP_MAX = 32;
    localparam int QUEUE_DEPTH = 32;

    localparam logic [3:0] PH_FLAG = 4'd0;
    localparam logic [3:0] PH_LIT  = 4'd1;
    localparam logic [3:0] PH_KIND = 4'd2;
    localparam logic [3:0] PH_OFFS = 4'd3;
    localparam logic [3:0] PH_LEN1 = 4'd4;
    localparam logic [3:0] PH_LEN2 = 4'd5;
    localparam logic [3:0] PH_LENX = 4'd6;

    localparam logic [2:0] ST_RUN     = 3'd0;
    localparam logic [2:0] ST_END     = 3'd1;
    localparam logic [2:0] ST_FULL    = 3'd2;
    localparam logic [2:0] ST_BADOFF  = 3'd3;
    localparam logic [2:0] ST_EXHAUST = 3'd4;

    localparam logic [11:0] LIMIT_RESET = 12'd2048;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       last_byte;
    } in_item_t;

    typedef struct packed {
        logic [7:0]  data_byte;
        logic        has_byte;
        logic        run_last;
        logic [2:0]  status;
        logic [11:0] produced_total;
    } out_item_t;

    // One decompressed byte waiting for its step to close.
    typedef struct packed {
        logic [7:0]  data_byte;
        logic [11:0] total;
    } res_ent_t;

    // Closing record of one input byte's work.
    typedef struct packed {
        logic [2:0]  status;
        logic [5:0]  count;
        logic [11:0] total;
    } step_rec_t;

    typedef struct packed {
        logic byte_full;
        logic rec_full;
        logic rec_avail;
    } q_stat_t;

endpackage

/* sv/lzs_front.sv */
// Front end: bit-serial LZS token decoder, history memory and match copier.
// Depends on lzs_pkg; pushes result bytes and step records into lzs_queue.
module lzs_front
    import lzs_pkg::*;
#(
    parameter int HISTORY_DEPTH = HISTORY_DEPTH_DEF
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_stall,
    input  in_item_t  in_data,
    input  logic      cfg_valid,
    input  logic [11:0] cfg_data,
    input  q_stat_t   q_stat,
    output logic      byte_push,
    output res_ent_t  byte_in,
    output logic      rec_push,
    output step_rec_t rec_in
);

    localparam int AW = $clog2(HISTORY_DEPTH);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_BIT  = 3'd1;
    localparam logic [2:0] S_RD   = 3'd2;
    localparam logic [2:0] S_WR   = 3'd3;
    localparam logic [2:0] S_END  = 3'd4;

    logic [2:0]  state_reg, state_next;
    logic [11:0] limit_reg;
    logic [7:0]  sh_reg, sh_next;
    logic        last_reg, last_next;
    logic [3:0]  rem_reg, rem_next;
    logic [3:0]  phase_reg, phase_next;
    logic [10:0] acc_reg, acc_next;
    logic [3:0]  bl_reg, bl_next;
    logic [10:0] off_reg, off_next;
    logic        short_reg, short_next;
    logic        fin_reg, fin_next;
    logic [2:0]  code_reg, code_next;
    logic [11:0] prod_reg, prod_next;
    logic [5:0]  stepn_reg, stepn_next;
    logic [3:0]  copy_reg, copy_next;

    logic [7:0]  hist_mem [HISTORY_DEPTH];
    logic [7:0]  rd_data_reg;
    logic [AW-1:0] rd_addr;
    logic        mem_we;

    logic [11:0] eff_limit;
    logic        bitv;
    logic [10:0] acc_new;
    logic [3:0]  copy_k;
    logic        put;
    logic [7:0]  put_data;
    logic        q_block;

    always_comb
    begin
        if (limit_reg == 12'd0)
            eff_limit = 12'd1;
        else if (17'(limit_reg) > 17'(HISTORY_DEPTH))
            eff_limit = 12'(HISTORY_DEPTH);
        else
            eff_limit = limit_reg;
    end

    assign bitv     = sh_reg[7];
    assign acc_new  = {acc_reg[9:0], bitv};
    assign rd_addr  = AW'(prod_reg - {1'b0, off_reg});
    assign q_block  = q_stat.byte_full && !stepn_reg[5];
    assign in_stall = (state_reg != S_IDLE);
    assign mem_we   = put;

    always_ff @(posedge clk)
    begin
        if (mem_we)
            hist_mem[AW'(prod_reg)] <= put_data;
        rd_data_reg <= hist_mem[rd_addr];
    end

    always_comb
    begin
        state_next = state_reg;
        sh_next    = sh_reg;
        last_next  = last_reg;
        rem_next   = rem_reg;
        phase_next = phase_reg;
        acc_next   = acc_reg;
        bl_next    = bl_reg;
        off_next   = off_reg;
        short_next = short_reg;
        fin_next   = fin_reg;
        code_next  = code_reg;
        prod_next  = prod_reg;
        stepn_next = stepn_reg;
        copy_next  = copy_reg;
        copy_k     = 4'd0;
        put        = 1'b0;
        put_data   = rd_data_reg;
        rec_push   = 1'b0;
        rec_in.status = fin_reg ? code_reg : (last_reg ? ST_EXHAUST : ST_RUN);
        rec_in.count  = stepn_reg;
        rec_in.total  = prod_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    sh_next    = in_data.in_byte;
                    last_next  = in_data.last_byte;
                    rem_next   = 4'd8;
                    stepn_next = 6'd0;
                    if (fin_reg)
                        state_next = S_END;
                    else if (prod_reg >= eff_limit)
                    begin
                        fin_next   = 1'b1;
                        code_next  = ST_FULL;
                        state_next = S_END;
                    end
                    else
                        state_next = S_BIT;
                end
            end
            S_BIT:
            begin
                if (!q_block)
                begin
                    sh_next  = {sh_reg[6:0], 1'b0};
                    rem_next = rem_reg - 4'd1;
                    unique case (phase_reg)
                        PH_KIND:
                        begin
                            short_next = bitv;
                            phase_next = PH_OFFS;
                            acc_next   = 11'd0;
                            bl_next    = bitv ? 4'd7 : 4'd11;
                        end
                        PH_LIT, PH_OFFS, PH_LEN1, PH_LEN2, PH_LENX:
                        begin
                            acc_next = acc_new;
                            bl_next  = bl_reg - 4'd1;
                            if (bl_reg == 4'd1)
                            begin
                                acc_next   = 11'd0;
                                bl_next    = 4'd0;
                                phase_next = PH_FLAG;
                                unique case (phase_reg)
                                    PH_LIT:
                                    begin
                                        put      = 1'b1;
                                        put_data = acc_new[7:0];
                                    end
                                    PH_OFFS:
                                    begin
                                        phase_next = phase_reg;
                                        if (short_reg && acc_new == 11'd0)
                                        begin
                                            fin_next  = 1'b1;
                                            code_next = ST_END;
                                        end
                                        else if (acc_new == 11'd0
                                                 || {1'b0, acc_new} > prod_reg)
                                        begin
                                            fin_next  = 1'b1;
                                            code_next = ST_BADOFF;
                                        end
                                        else
                                        begin
                                            off_next   = acc_new;
                                            phase_next = PH_LEN1;
                                            bl_next    = 4'd2;
                                        end
                                    end
                                    PH_LEN1:
                                    begin
                                        if (acc_new[1:0] != 2'd3)
                                            copy_k = {2'b00, acc_new[1:0]} + 4'd2;
                                        else
                                        begin
                                            copy_k     = 4'd5;
                                            phase_next = PH_LEN2;
                                            bl_next    = 4'd2;
                                        end
                                    end
                                    PH_LEN2:
                                    begin
                                        if (acc_new[1:0] != 2'd3)
                                            copy_k = {2'b00, acc_new[1:0]};
                                        else
                                        begin
                                            copy_k     = 4'd3;
                                            phase_next = PH_LENX;
                                            bl_next    = 4'd4;
                                        end
                                    end
                                    default:
                                    begin
                                        copy_k = acc_new[3:0];
                                        if (acc_new[3:0] == 4'd15)
                                        begin
                                            phase_next = PH_LENX;
                                            bl_next    = 4'd4;
                                        end
                                    end
                                endcase
                            end
                        end
                        default:
                        begin
                            if (bitv)
                                phase_next = PH_KIND;
                            else
                            begin
                                phase_next = PH_LIT;
                                acc_next   = 11'd0;
                                bl_next    = 4'd8;
                            end
                        end
                    endcase
                end
            end
            S_RD:
            begin
                state_next = S_WR;
            end
            S_WR:
            begin
                if (!q_block)
                begin
                    put       = 1'b1;
                    copy_next = copy_reg - 4'd1;
                end
            end
            S_END:
            begin
                if (!q_stat.rec_full)
                begin
                    rec_push = 1'b1;
                    if (!fin_reg && last_reg)
                    begin
                        fin_next  = 1'b1;
                        code_next = ST_EXHAUST;
                    end
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        // Writing one output byte: history, count, queue and the limit check.
        if (put)
        begin
            prod_next = prod_reg + 12'd1;
            if (!stepn_reg[5])
                stepn_next = stepn_reg + 6'd1;
            if (prod_reg + 12'd1 >= eff_limit)
            begin
                fin_next  = 1'b1;
                code_next = ST_FULL;
            end
        end

        if (state_reg == S_BIT && !q_block)
        begin
            if (copy_k != 4'd0 && !fin_next)
            begin
                copy_next  = copy_k;
                state_next = S_RD;
            end
            else
                state_next = (fin_next || rem_next == 4'd0) ? S_END : S_BIT;
        end
        else if (state_reg == S_WR && !q_block)
        begin
            if (fin_next || copy_reg == 4'd1)
                state_next = (fin_next || rem_reg == 4'd0) ? S_END : S_BIT;
            else
                state_next = S_RD;
        end
    end

    assign byte_push         = put && !stepn_reg[5];
    assign byte_in.data_byte = put_data;
    assign byte_in.total     = prod_reg + 12'd1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            limit_reg <= LIMIT_RESET;
            last_reg  <= 1'b0;
            rem_reg   <= 4'd0;
            phase_reg <= PH_FLAG;
            acc_reg   <= 11'd0;
            bl_reg    <= 4'd0;
            off_reg   <= 11'd0;
            short_reg <= 1'b0;
            fin_reg   <= 1'b0;
            code_reg  <= ST_RUN;
            prod_reg  <= 12'd0;
            stepn_reg <= 6'd0;
            copy_reg  <= 4'd0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_valid)
                limit_reg <= cfg_data;
            last_reg  <= last_next;
            rem_reg   <= rem_next;
            phase_reg <= phase_next;
            acc_reg   <= acc_next;
            bl_reg    <= bl_next;
            off_reg   <= off_next;
            short_reg <= short_next;
            fin_reg   <= fin_next;
            code_reg  <= code_next;
            prod_reg  <= prod_next;
            stepn_reg <= stepn_next;
            copy_reg  <= copy_next;
        end
    end

    always_ff @(posedge clk)
    begin
        sh_reg <= sh_next;
    end

endmodule

/* sv/lzs_queue.sv */
// Queue between front and back: result bytes plus closing records per step.
// Depends on lzs_pkg.
module lzs_queue
    import lzs_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      byte_push,
    input  res_ent_t  byte_in,
    input  logic      byte_pop,
    output res_ent_t  byte_head,
    input  logic      rec_push,
    input  step_rec_t rec_in,
    input  logic      rec_pop,
    output step_rec_t rec_head,
    output q_stat_t   q_stat
);

    localparam int QW = $clog2(QUEUE_DEPTH);

    res_ent_t  byte_mem [QUEUE_DEPTH];
    logic [QW-1:0] bwr_reg, brd_reg;
    logic [QW:0]   bcnt_reg;

    step_rec_t rec_mem [2];
    logic      rwr_reg, rrd_reg;
    logic [1:0] rcnt_reg;

    assign byte_head        = byte_mem[brd_reg];
    assign rec_head         = rec_mem[rrd_reg];
    assign q_stat.byte_full = (bcnt_reg == (QW+1)'(QUEUE_DEPTH));
    assign q_stat.rec_full  = (rcnt_reg == 2'd2);
    assign q_stat.rec_avail = (rcnt_reg != 2'd0);

    always_ff @(posedge clk)
    begin
        if (byte_push)
            byte_mem[bwr_reg] <= byte_in;
        if (rec_push)
            rec_mem[rwr_reg] <= rec_in;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bwr_reg  <= '0;
            brd_reg  <= '0;
            bcnt_reg <= '0;
            rwr_reg  <= 1'b0;
            rrd_reg  <= 1'b0;
            rcnt_reg <= 2'd0;
        end
        else
        begin
            if (byte_push)
                bwr_reg <= bwr_reg + 1'b1;
            if (byte_pop)
                brd_reg <= brd_reg + 1'b1;
            bcnt_reg <= bcnt_reg + (QW+1)'(byte_push) - (QW+1)'(byte_pop);
            if (rec_push)
                rwr_reg <= !rwr_reg;
            if (rec_pop)
                rrd_reg <= !rrd_reg;
            rcnt_reg <= rcnt_reg + 2'(rec_push) - 2'(rec_pop);
        end
    end

endmodule

/* sv/lzs_back.sv */
// Back end: replays each closed step as result beats with its final status.
// Depends on lzs_pkg; drains lzs_queue into the output register.
module lzs_back
    import lzs_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  q_stat_t   q_stat,
    input  res_ent_t  byte_head,
    input  step_rec_t rec_head,
    output logic      byte_pop,
    output logic      rec_pop,
    output logic      out_valid,
    input  logic      out_stall,
    output out_item_t out_data
);

    logic      out_valid_reg, out_valid_next;
    out_item_t out_reg, out_next;
    logic [5:0] cnt_reg, cnt_next;
    logic       load;
    logic       is_last;

    assign load    = !out_valid_reg || !out_stall;
    assign is_last = (cnt_reg + 6'd1 == rec_head.count);

    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_next       = out_reg;
        cnt_next       = cnt_reg;
        byte_pop       = 1'b0;
        rec_pop        = 1'b0;
        if (load)
        begin
            out_valid_next = q_stat.rec_avail;
            if (q_stat.rec_avail)
            begin
                out_next.status = rec_head.status;
                if (rec_head.count == 6'd0)
                begin
                    out_next.data_byte      = 8'd0;
                    out_next.has_byte       = 1'b0;
                    out_next.run_last       = 1'b1;
                    out_next.produced_total = rec_head.total;
                    rec_pop                 = 1'b1;
                end
                else
                begin
                    out_next.data_byte      = byte_head.data_byte;
                    out_next.has_byte       = 1'b1;
                    out_next.run_last       = is_last;
                    out_next.produced_total = byte_head.total;
                    byte_pop                = 1'b1;
                    rec_pop                 = is_last;
                    cnt_next                = is_last ? 6'd0 : cnt_reg + 6'd1;
                end
            end
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            cnt_reg       <= 6'd0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            cnt_reg       <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg <= out_next;
    end

endmodule

/* sv/lzs_stream_decompressor.sv */
// LZS stream decompressor top level. An input beat is taken in S_IDLE, then decoded one
// compressed bit per S_BIT step (up to 8), each match byte copied through S_RD, for the
// registered history read, and S_WR; the step closes in S_END. Results leave at one beat
// per cycle while out_stall is low. No new input beat is taken until the last one is done.
// Reset (rst_n, async) clears the decoder, counts, queue and output limit (2048);
// the history memory is not cleared, since only bytes written in this stream are read.
module lzs_stream_decompressor
    import lzs_pkg::*;
#(
    parameter int HISTORY_DEPTH = HISTORY_DEPTH_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  in_item_t    in_data,
    output logic        out_valid,
    input  logic        out_stall,
    output out_item_t   out_data,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [11:0] cfg_data
);

    q_stat_t   q_stat;
    logic      byte_push, byte_pop, rec_push, rec_pop;
    res_ent_t  byte_in, byte_head;
    step_rec_t rec_in, rec_head;

    assign cfg_ready = 1'b1;

    lzs_front #(.HISTORY_DEPTH(HISTORY_DEPTH)) u_front
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .cfg_valid (cfg_valid),
        .cfg_data  (cfg_data),
        .q_stat    (q_stat),
        .byte_push (byte_push),
        .byte_in   (byte_in),
        .rec_push  (rec_push),
        .rec_in    (rec_in)
    );

    lzs_queue u_queue
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .byte_push (byte_push),
        .byte_in   (byte_in),
        .byte_pop  (byte_pop),
        .byte_head (byte_head),
        .rec_push  (rec_push),
        .rec_in    (rec_in),
        .rec_pop   (rec_pop),
        .rec_head  (rec_head),
        .q_stat    (q_stat)
    );

    lzs_back u_back
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_stat    (q_stat),
        .byte_head (byte_head),
        .rec_head  (rec_head),
        .byte_pop  (byte_pop),
        .rec_pop   (rec_pop),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

    // The byte queue must never be written while full.
    assert property (@(posedge clk) disable iff (!rst_n)
        !(byte_push && q_stat.byte_full))
        else $error("byte queue overflow");

    // A beat without a byte always closes its step.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_data.has_byte) |-> out_data.run_last)
        else $error("empty result not marked last");

    // A byte beat always counts at least one byte.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_data.has_byte) |-> (out_data.produced_total != 12'd0))
        else $error("byte result with zero total");

    // Bytes are only popped while a closed step is waiting.
    assert property (@(posedge clk) disable iff (!rst_n)
        byte_pop |-> q_stat.rec_avail)
        else $error("byte popped without a step record");

endmodule
